>>> hw/rtl/lge_pkg.sv
// Package for the life generation engine: payload structs, codes and
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package lge_pkg;

    // Default store size
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Register reset values
    localparam logic [6:0] RST_GRID_WIDTH  = 7'd64;
    localparam logic [6:0] RST_GRID_HEIGHT = 7'd64;
    localparam logic [6:0] RST_GEN_LIMIT   = 7'd100;

    // Register indexes
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GEN_LIMIT   = 2'd2;

    // Item modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;  // no state change

    // Row read kinds
    localparam logic [1:0] RD_WIN  = 2'd0;  // row into neighbor window
    localparam logic [1:0] RD_ZCHK = 2'd1;  // row outside active area, must be empty
    localparam logic [1:0] RD_CELL = 2'd2;  // row of the addressed cell

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       alive_in;
    } in_item_t;

    typedef struct packed {
        logic       cell_value;
        logic       grid_stable;
        logic       restart;
        logic [6:0] generation;
    } out_item_t;

    typedef struct packed {
        logic       load_item;
        logic       adv_start;
        logic       rd_en;
        logic [1:0] rd_kind;
        logic       cell_wr;
        logic       cell_cap;
        logic       load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       in_range;
    } dp_status_t;

endpackage

>>> hw/rtl/lge_ctrl.sv
// Controller of the life generation engine: item handshake, row sequencing
// and result handshake. Depends on lge_pkg.
`timescale 1ns / 1ps

module lge_ctrl #(
    parameter int MAX_HEIGHT = lge_pkg::DEF_MAX_HEIGHT,
    parameter int YW         = $clog2(MAX_HEIGHT),
    parameter int HW         = YW + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  lge_pkg::dp_status_t status,
    input  logic [HW-1:0]       rows_eff,
    output lge_pkg::ctl_cmd_t   cmd,
    output logic [YW-1:0]       rd_addr
);

    localparam int CW = YW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADV_WIN,
        S_ADV_TAIL,
        S_ADV_DRAIN,
        S_CELL_RD,
        S_CELL_USE,
        S_FINISH
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           drain_reg, drain_next;
    logic           oval_reg, oval_next;
    logic [CW-1:0]  hx;
    logic [CW-1:0]  win_addr;
    logic           out_free;

    assign hx           = CW'(rows_eff);
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = oval_reg;
    assign out_free     = !oval_reg || !result_stall;

    // Wrapped row order for the window: last row, then 0..h-1, then row 0
    always_comb
    begin
        if (k_reg == '0)
            win_addr = hx - CW'(1);
        else if (k_reg <= hx)
            win_addr = k_reg - CW'(1);
        else
            win_addr = '0;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        oval_next  = oval_reg;
        cmd        = '0;
        rd_addr    = win_addr[YW-1:0];
        if (oval_reg && !result_stall)
            oval_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.mode == lge_pkg::MODE_ADVANCE)
                begin
                    cmd.adv_start = 1'b1;
                    k_next        = '0;
                    state_next    = S_ADV_WIN;
                end
                else if ((status.mode == lge_pkg::MODE_WRITE ||
                          status.mode == lge_pkg::MODE_READ) && status.in_range)
                    state_next = S_CELL_RD;
                else
                    state_next = S_FINISH;
            end
            S_ADV_WIN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = lge_pkg::RD_WIN;
                k_next      = k_reg + CW'(1);
                drain_next  = 1'b0;
                if (k_reg == hx + CW'(1))
                begin
                    if (hx == CW'(MAX_HEIGHT))
                        state_next = S_ADV_DRAIN;
                    else
                    begin
                        k_next     = hx;
                        state_next = S_ADV_TAIL;
                    end
                end
            end
            S_ADV_TAIL:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = lge_pkg::RD_ZCHK;
                rd_addr     = k_reg[YW-1:0];
                k_next      = k_reg + CW'(1);
                if (k_reg == CW'(MAX_HEIGHT - 1))
                    state_next = S_ADV_DRAIN;
            end
            S_ADV_DRAIN:
            begin
                // wait for the read and window stages to empty
                drain_next = 1'b1;
                if (drain_reg)
                    state_next = S_FINISH;
            end
            S_CELL_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = lge_pkg::RD_CELL;
                state_next  = S_CELL_USE;
            end
            S_CELL_USE:
            begin
                if (status.mode == lge_pkg::MODE_WRITE)
                    cmd.cell_wr = 1'b1;
                else
                    cmd.cell_cap = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    oval_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            drain_reg <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

>>> hw/rtl/lge_datapath.sv
// Datapath of the life generation engine: two row memories in ping-pong,
// row valid flags, neighbor window, next-row logic and counters. Depends on lge_pkg.
`timescale 1ns / 1ps

module lge_datapath #(
    parameter int MAX_WIDTH  = lge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lge_pkg::DEF_MAX_HEIGHT,
    parameter int YW         = $clog2(MAX_HEIGHT),
    parameter int HW         = YW + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lge_pkg::in_item_t   item,
    input  lge_pkg::ctl_cmd_t   cmd,
    input  logic [YW-1:0]       rd_addr,
    output lge_pkg::dp_status_t status,
    output logic [HW-1:0]       rows_eff,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    output lge_pkg::out_item_t  result
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WEW = $clog2(MAX_WIDTH + 1);

    // Row memories and registered read data
    logic [MAX_WIDTH-1:0]  mem0 [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0]  mem1 [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0]  q0_reg, q1_reg;
    logic [MAX_HEIGHT-1:0] vld0_reg, vld1_reg;
    logic                  vq_reg;

    logic [6:0]            width_reg, height_reg, limit_reg;
    logic [6:0]            gen_reg;
    logic                  sel_reg;
    lge_pkg::in_item_t     item_reg;
    logic                  cell_bit_reg;
    logic                  pend_reg;
    logic [1:0]            kind_reg;
    logic [MAX_WIDTH-1:0]  win0_reg, win1_reg, win2_reg;
    logic [1:0]            fill_reg;
    logic                  win_new_reg;
    logic [YW-1:0]         orow_reg;
    logic                  stable_reg;
    lge_pkg::out_item_t    result_reg;

    logic [WEW-1:0]        cols_eff;
    logic [XW-1:0]         wm1;
    logic [15:0]           x_ext, y_ext;
    logic [XW-1:0]         item_xa;
    logic [YW-1:0]         item_ya;
    logic [YW-1:0]         ra;
    logic [MAX_WIDTH-1:0]  rdata;
    logic [MAX_WIDTH-1:0]  cell_row;
    logic [MAX_WIDTH-1:0]  next_row;
    logic                  adv_wr;
    logic                  we0, we1;
    logic [YW-1:0]         wa;
    logic [MAX_WIDTH-1:0]  wd;
    logic [7:0]            gen_inc;
    logic                  restart;

    // Effective sizes: zero acts as one, oversize acts as the store size
    always_comb
    begin
        if (width_reg == 7'd0)
            cols_eff = WEW'(1);
        else if (9'(width_reg) > 9'(MAX_WIDTH))
            cols_eff = WEW'(MAX_WIDTH);
        else
            cols_eff = WEW'(width_reg);
        if (height_reg == 7'd0)
            rows_eff = HW'(1);
        else if (9'(height_reg) > 9'(MAX_HEIGHT))
            rows_eff = HW'(MAX_HEIGHT);
        else
            rows_eff = HW'(height_reg);
    end

    assign wm1     = XW'(cols_eff - WEW'(1));
    assign x_ext   = 16'(item_reg.cell_x);
    assign y_ext   = 16'(item_reg.cell_y);
    assign item_xa = x_ext[XW-1:0];
    assign item_ya = y_ext[YW-1:0];

    assign status.mode     = item_reg.mode;
    assign status.in_range = (x_ext < 16'(cols_eff)) && (y_ext < 16'(rows_eff));

    assign ra    = (cmd.rd_kind == lge_pkg::RD_CELL) ? item_ya : rd_addr;
    assign rdata = (sel_reg ? q1_reg : q0_reg) & {MAX_WIDTH{vq_reg}};

    // Read-modify-write row for a cell write
    always_comb
    begin
        cell_row          = rdata;
        cell_row[item_xa] = item_reg.alive_in;
    end

    // Next generation of the center row, wrapped at the active width
    always_comb
    begin
        logic [MAX_WIDTH+1:0] ux, mx, dx;
        logic                 ul, ml, dl, ur, mr, dr;
        logic [3:0]           n;
        ux = {1'b0, win0_reg, 1'b0};
        mx = {1'b0, win1_reg, 1'b0};
        dx = {1'b0, win2_reg, 1'b0};
        next_row = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            if (i == 0)
            begin
                ul = win0_reg[wm1];
                ml = win1_reg[wm1];
                dl = win2_reg[wm1];
            end
            else
            begin
                ul = ux[i];
                ml = mx[i];
                dl = dx[i];
            end
            if (i == int'(cols_eff) - 1)
            begin
                ur = win0_reg[0];
                mr = win1_reg[0];
                dr = win2_reg[0];
            end
            else
            begin
                ur = ux[i+2];
                mr = mx[i+2];
                dr = dx[i+2];
            end
            n = 4'(ul) + 4'(ux[i+1]) + 4'(ur) + 4'(ml) + 4'(mr)
              + 4'(dl) + 4'(dx[i+1]) + 4'(dr);
            if (i < int'(cols_eff))
                next_row[i] = win1_reg[i] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
        end
    end

    // Memory write selection
    assign adv_wr = win_new_reg && (fill_reg == 2'd3);
    assign we0    = (adv_wr && sel_reg) || (cmd.cell_wr && !sel_reg);
    assign we1    = (adv_wr && !sel_reg) || (cmd.cell_wr && sel_reg);
    assign wa     = adv_wr ? orow_reg : item_ya;
    assign wd     = adv_wr ? next_row : cell_row;

    // Row memories
    always_ff @(posedge clk)
    begin
        if (we0)
            mem0[wa] <= wd;
        if (we1)
            mem1[wa] <= wd;
        if (cmd.rd_en)
        begin
            q0_reg <= mem0[ra];
            q1_reg <= mem1[ra];
        end
    end

    // Generation update
    assign gen_inc = 8'(gen_reg) + 8'd1;
    assign restart = (gen_inc >= 8'(limit_reg)) || stable_reg;

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg     <= '0;
            vld1_reg     <= '0;
            vq_reg       <= 1'b0;
            width_reg    <= lge_pkg::RST_GRID_WIDTH;
            height_reg   <= lge_pkg::RST_GRID_HEIGHT;
            limit_reg    <= lge_pkg::RST_GEN_LIMIT;
            gen_reg      <= '0;
            sel_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            kind_reg     <= lge_pkg::RD_WIN;
            fill_reg     <= '0;
            win_new_reg  <= 1'b0;
            orow_reg     <= '0;
            stable_reg   <= 1'b0;
        end
        else
        begin
            // configuration
            if (cfg_we)
            begin
                case (cfg_index)
                    lge_pkg::CFG_GRID_WIDTH:  width_reg  <= cfg_data;
                    lge_pkg::CFG_GRID_HEIGHT: height_reg <= cfg_data;
                    lge_pkg::CFG_GEN_LIMIT:   limit_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // read stage
            pend_reg <= cmd.rd_en;
            if (cmd.rd_en)
            begin
                kind_reg <= cmd.rd_kind;
                vq_reg   <= sel_reg ? vld1_reg[ra] : vld0_reg[ra];
            end

            // window stage
            win_new_reg <= pend_reg && (kind_reg == lge_pkg::RD_WIN);
            if (pend_reg && kind_reg == lge_pkg::RD_WIN && fill_reg != 2'd3)
                fill_reg <= fill_reg + 2'd1;
            if (pend_reg && kind_reg == lge_pkg::RD_ZCHK && rdata != '0)
                stable_reg <= 1'b0;

            // next-row write stage
            if (adv_wr)
            begin
                orow_reg <= orow_reg + YW'(1);
                if (next_row != win1_reg)
                    stable_reg <= 1'b0;
                if (sel_reg)
                    vld0_reg[orow_reg] <= 1'b1;
                else
                    vld1_reg[orow_reg] <= 1'b1;
            end

            if (cmd.cell_wr)
            begin
                if (sel_reg)
                    vld1_reg[item_ya] <= 1'b1;
                else
                    vld0_reg[item_ya] <= 1'b1;
            end

            // start of an advance: empty destination grid
            if (cmd.adv_start)
            begin
                fill_reg    <= '0;
                win_new_reg <= 1'b0;
                orow_reg    <= '0;
                stable_reg  <= 1'b1;
                if (sel_reg)
                    vld0_reg <= '0;
                else
                    vld1_reg <= '0;
            end

            // end of an advance: restart clears both grids, else swap
            if (cmd.load_out && item_reg.mode == lge_pkg::MODE_ADVANCE)
            begin
                if (restart)
                begin
                    gen_reg  <= '0;
                    vld0_reg <= '0;
                    vld1_reg <= '0;
                end
                else
                begin
                    gen_reg <= gen_inc[6:0];
                    sel_reg <= !sel_reg;
                end
            end
        end
    end

    // Window shift, item and result payload
    always_ff @(posedge clk)
    begin
        if (pend_reg && kind_reg == lge_pkg::RD_WIN)
        begin
            win0_reg <= win1_reg;
            win1_reg <= win2_reg;
            win2_reg <= rdata;
        end
        if (cmd.load_item)
        begin
            item_reg     <= item;
            cell_bit_reg <= 1'b0;
        end
        if (cmd.cell_cap)
            cell_bit_reg <= rdata[item_xa];
        if (cmd.load_out)
        begin
            result_reg.cell_value  <= (item_reg.mode == lge_pkg::MODE_READ) && cell_bit_reg;
            result_reg.grid_stable <= 1'b0;
            result_reg.restart     <= 1'b0;
            result_reg.generation  <= gen_reg;
            if (item_reg.mode == lge_pkg::MODE_ADVANCE)
            begin
                result_reg.grid_stable <= stable_reg;
                result_reg.restart     <= restart;
                result_reg.generation  <= restart ? 7'd0 : gen_inc[6:0];
            end
        end
    end

    assign result = result_reg;

endmodule

>>> hw/rtl/life_generation_engine.sv
// Sequence: a cell write or read is loaded as a result after the dispatch, cell read and
// cell use states; an advance reads one row per cycle through the row memory port.
// Mode 3 and cells outside the active area skip to finish. One item is in work at a
// time; the next is accepted in the cycle after the result is loaded, even while it waits.
// Reset clears control state and the row valid flags, so both grids read
// as all dead at once with no clearing pass. Depends on lge_pkg, lge_ctrl, lge_datapath.
`timescale 1ns / 1ps

module life_generation_engine #(
    parameter int MAX_WIDTH  = lge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lge_pkg::DEF_MAX_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  lge_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output lge_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int HW = YW + 1;

    lge_pkg::ctl_cmd_t   cmd;
    lge_pkg::dp_status_t status;
    logic [YW-1:0]       rd_addr;
    logic [HW-1:0]       rows_eff;

    assign cfg_ready = 1'b1;

    lge_ctrl #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .YW         (YW),
        .HW         (HW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .rows_eff     (rows_eff),
        .cmd          (cmd),
        .rd_addr      (rd_addr)
    );

    lge_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .YW         (YW),
        .HW         (HW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .status    (status),
        .rows_eff  (rows_eff),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

>>> sim/tb_top.sv
// Testbench for life_generation_engine: directed and random cell writes, reads and
// generation advances, checked against a behavioral grid model. Depends on lge_pkg and life_generation_engine.
`timescale 1ns / 1ps

module tb_top;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 300;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    lge_pkg::in_item_t  item;
    logic               result_valid;
    logic               result_stall;
    lge_pkg::out_item_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_data;

    life_generation_engine dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Model state
    bit        life_grid [GW*GH];
    bit [6:0]  gen_count;
    bit [6:0]  width_reg  = lge_pkg::RST_GRID_WIDTH;
    bit [6:0]  height_reg = lge_pkg::RST_GRID_HEIGHT;
    bit [6:0]  limit_reg  = lge_pkg::RST_GEN_LIMIT;

    lge_pkg::in_item_t  pending_items[$];
    lge_pkg::out_item_t expected_results[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles;
    bit        item_taken;
    bit        long_hold_req = 1'b0;
    bit        hold_done;
    int        hold_count;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int eff_size(bit [6:0] v, int maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int wrap_step(int p, int d, int size);
        if (d < 0)
            return (p == 0) ? size - 1 : p - 1;
        if (d > 0)
            return (p + 1 > size - 1) ? 0 : p + 1;
        return p;
    endfunction

    // Apply one transaction to the grid model and return its result
    function automatic lge_pkg::out_item_t life_predict(lge_pkg::in_item_t it);
        lge_pkg::out_item_t r;
        bit        nxt [GW*GH];
        int        w;
        int        h;
        int        n;
        bit        same;
        bit [7:0]  cnt;
        w = eff_size(width_reg, GW);
        h = eff_size(height_reg, GH);
        r = '0;
        if (it.mode == lge_pkg::MODE_WRITE)
        begin
            if (it.cell_x < w && it.cell_y < h)
                life_grid[it.cell_y*GW + it.cell_x] = it.alive_in;
        end
        else if (it.mode == lge_pkg::MODE_READ)
        begin
            if (it.cell_x < w && it.cell_y < h)
                r.cell_value = life_grid[it.cell_y*GW + it.cell_x];
        end
        else if (it.mode == lge_pkg::MODE_ADVANCE)
        begin
            foreach (nxt[i])
                nxt[i] = 1'b0;
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    n = 0;
                    for (int b = -1; b <= 1; b++)
                        for (int a = -1; a <= 1; a++)
                            if (a != 0 || b != 0)
                                n += life_grid[wrap_step(y, b, h)*GW + wrap_step(x, a, w)];
                    if (life_grid[y*GW + x])
                        nxt[y*GW + x] = (n == 2 || n == 3);
                    else
                        nxt[y*GW + x] = (n == 3);
                end
            same = 1'b1;
            foreach (nxt[i])
                if (nxt[i] != life_grid[i])
                    same = 1'b0;
            r.grid_stable = same;
            cnt = 8'(gen_count) + 8'd1;
            if (cnt >= 8'(limit_reg) || same)
            begin
                r.restart = 1'b1;
                gen_count = '0;
                foreach (life_grid[i])
                    life_grid[i] = 1'b0;
            end
            else
            begin
                gen_count = cnt[6:0];
                life_grid = nxt;
            end
        end
        r.generation = gen_count;
        return r;
    endfunction

    // Driver: feeds pending items at the falling edge, holds a stalled one
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || item_taken)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= pending_items[0];
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver back-pressure, with one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_count   <= 0;
            hold_done    <= 1'b0;
        end
        else if (long_hold_req && !hold_done)
        begin
            result_stall <= 1'b1;
            hold_count   <= hold_count + 1;
            if (hold_count == LONG_HOLD - 1)
                hold_done <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor, predictor and watchdog
    always @(posedge clk)
    begin
        lge_pkg::out_item_t exp_r;
        if (!rst_n)
        begin
            item_taken   <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            item_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(life_predict(item));
                void'(pending_items.pop_front());
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.cell_value !== exp_r.cell_value)
                    begin
                        $error("cell_value exp %0d got %0d", exp_r.cell_value, result.cell_value);
                        errors++;
                    end
                    if (result.grid_stable !== exp_r.grid_stable)
                    begin
                        $error("grid_stable exp %0d got %0d", exp_r.grid_stable,
                               result.grid_stable);
                        errors++;
                    end
                    if (result.restart !== exp_r.restart)
                    begin
                        $error("restart exp %0d got %0d", exp_r.restart, result.restart);
                        errors++;
                    end
                    if (result.generation !== exp_r.generation)
                    begin
                        $error("generation exp %0d got %0d", exp_r.generation,
                               result.generation);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (GH + 20) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            lge_pkg::CFG_GRID_WIDTH:  width_reg  = val;
            lge_pkg::CFG_GRID_HEIGHT: height_reg = val;
            lge_pkg::CFG_GEN_LIMIT:   limit_reg  = val;
            default: ;
        endcase
    endtask

    task automatic queue_item(logic [1:0] m, int x, int y, bit a);
        lge_pkg::in_item_t it;
        it.mode     = m;
        it.cell_x   = x[5:0];
        it.cell_y   = y[5:0];
        it.alive_in = a;
        pending_items.push_back(it);
    endtask

    // Random mix: seeding writes and reads inside a span-sized area, advances and random-mode items
    task automatic queue_random(int n, int span);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                queue_item(lge_pkg::MODE_WRITE, $urandom_range(span - 1),
                           $urandom_range(span - 1), $urandom_range(3) != 0);
            else if (r < 75)
                queue_item(lge_pkg::MODE_READ, $urandom_range(span - 1),
                           $urandom_range(span - 1), 1'b0);
            else if (r < 92)
                queue_item(lge_pkg::MODE_ADVANCE, $urandom_range(63), $urandom_range(63),
                           1'($urandom_range(1)));
            else
                queue_item(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                           1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: full grid corners with wrap, corner reads, advances and a mode 3 item
        queue_item(lge_pkg::MODE_WRITE, 63, 63, 1'b1);
        queue_item(lge_pkg::MODE_WRITE, 0, 63, 1'b1);
        queue_item(lge_pkg::MODE_WRITE, 63, 0, 1'b1);
        queue_item(lge_pkg::MODE_READ, 63, 63, 1'b0);
        queue_item(lge_pkg::MODE_READ, 0, 0, 1'b0);
        queue_item(lge_pkg::MODE_ADVANCE, 0, 0, 1'b0);
        queue_item(lge_pkg::MODE_READ, 0, 0, 1'b0);
        queue_item(lge_pkg::MODE_UNUSED, 63, 63, 1'b1);
        queue_item(lge_pkg::MODE_ADVANCE, 0, 0, 1'b0);
        wait_drained();

        // Small torus, limit 1: every advance restarts
        write_reg(lge_pkg::CFG_GRID_WIDTH, 7'd5);
        write_reg(lge_pkg::CFG_GRID_HEIGHT, 7'd5);
        write_reg(lge_pkg::CFG_GEN_LIMIT, 7'd1);
        queue_item(lge_pkg::MODE_WRITE, 1, 2, 1'b1);
        queue_item(lge_pkg::MODE_WRITE, 2, 2, 1'b1);
        queue_item(lge_pkg::MODE_WRITE, 3, 2, 1'b1);
        queue_item(lge_pkg::MODE_WRITE, 40, 40, 1'b1);
        queue_item(lge_pkg::MODE_READ, 40, 40, 1'b0);
        queue_item(lge_pkg::MODE_ADVANCE, 0, 0, 1'b0);
        queue_item(lge_pkg::MODE_READ, 2, 2, 1'b0);
        wait_drained();

        // Zero and oversize sizes, limit zero, then tiny grids
        write_reg(lge_pkg::CFG_GRID_WIDTH, 7'd0);
        write_reg(lge_pkg::CFG_GRID_HEIGHT, 7'd127);
        write_reg(lge_pkg::CFG_GEN_LIMIT, 7'd0);
        queue_item(lge_pkg::MODE_WRITE, 0, 10, 1'b1);
        queue_item(lge_pkg::MODE_WRITE, 1, 10, 1'b1);
        queue_item(lge_pkg::MODE_READ, 0, 10, 1'b0);
        queue_item(lge_pkg::MODE_ADVANCE, 0, 0, 1'b0);
        wait_drained();
        write_reg(lge_pkg::CFG_GRID_WIDTH, 7'd2);
        write_reg(lge_pkg::CFG_GRID_HEIGHT, 7'd2);
        write_reg(lge_pkg::CFG_GEN_LIMIT, 7'd127);
        queue_item(lge_pkg::MODE_WRITE, 0, 0, 1'b1);
        queue_item(lge_pkg::MODE_WRITE, 1, 1, 1'b1);
        queue_item(lge_pkg::MODE_ADVANCE, 0, 0, 1'b0);
        queue_item(lge_pkg::MODE_READ, 0, 0, 1'b0);
        wait_drained();

        // Random phase one: sender busy, receiver heavy back-pressure, long hold-off
        write_reg(lge_pkg::CFG_GRID_WIDTH, 7'd8);
        write_reg(lge_pkg::CFG_GRID_HEIGHT, 7'd6);
        write_reg(lge_pkg::CFG_GEN_LIMIT, 7'd20);
        send_idle_pct = 23;
        recv_idle_pct = 85;
        @(negedge clk);
        long_hold_req = 1'b1;
        queue_random(40, 8);
        wait_drained();

        // Random phase two: roles swapped, full size grid
        write_reg(lge_pkg::CFG_GRID_WIDTH, 7'd64);
        write_reg(lge_pkg::CFG_GRID_HEIGHT, 7'd64);
        write_reg(lge_pkg::CFG_GEN_LIMIT, 7'd100);
        send_idle_pct = 85;
        recv_idle_pct = 23;
        queue_random(36, 64);
        wait_drained();

        // Random phase three: no idling
        write_reg(lge_pkg::CFG_GRID_WIDTH, 7'd7);
        write_reg(lge_pkg::CFG_GRID_HEIGHT, 7'd9);
        write_reg(lge_pkg::CFG_GEN_LIMIT, 7'd5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(40, 9);
        wait_drained();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
